/* src/assert_macros.svh */
// assertion helpers used by the expander unit to check its own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AAQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aaq assertion failed");

// next-cycle implication
`define AAQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aaq assertion failed");

`endif

/* src/aaq_pkg.sv */
// ----------------------------------------------------------------------------
// aaq_pkg
// Types, constants and triangle tables of the line and quad expander.
// ----------------------------------------------------------------------------
package aaq_pkg;

   localparam int INDEX_BITS_DEF      = 16;
   localparam int COORD_FRAC_BITS_DEF = 4;

   localparam int ACTION_W = 2;
   localparam int COORD_W  = 16;
   localparam int WIDTH_W  = 12;
   localparam int COLOR_W  = 8;
   localparam int IDX_W    = 16;

   // arithmetic widths of the offset search
   localparam int MAG_W    = 16;
   localparam int Q4_W     = 14;
   localparam int A_W      = 30;
   localparam int A2_W     = 60;
   localparam int SQ_W     = 32;
   localparam int LEN2_W   = 33;
   localparam int LEN_LO_W = 17;
   localparam int LEN_HI_W = LEN2_W - LEN_LO_W;
   localparam int LO_BITS  = 12;
   localparam int T_W      = 13;
   localparam int T2_W     = 26;
   localparam int PLO_W    = T2_W + LEN_LO_W;
   localparam int PHI_W    = T2_W + LEN_HI_W;
   localparam int CMP_W    = 62;
   localparam int OFF_W    = 13;
   localparam int SUM_W    = 17;
   localparam int BIT_CNT_W  = 4;
   localparam int EMIT_CNT_W = 4;

   localparam logic [ACTION_W-1:0] ACT_LINE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RECT  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [EMIT_CNT_W-1:0] LAST_LINE   = 4'd13;
   localparam logic [EMIT_CNT_W-1:0] LAST_RECT   = 4'd5;
   localparam logic [EMIT_CNT_W-1:0] LINE_VERTS  = 4'd8;
   localparam logic [EMIT_CNT_W-1:0] RECT_VERTS  = 4'd4;

   localparam logic [2:0] LINE_TRI_TAB [0:5][0:2] = '{
      '{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd3, 3'd2}, '{3'd2, 3'd3, 3'd5},
      '{3'd2, 3'd5, 3'd4}, '{3'd4, 3'd5, 3'd7}, '{3'd4, 3'd7, 3'd6}
   };
   localparam logic [2:0] RECT_TRI_TAB [0:1][0:2] = '{
      '{3'd0, 3'd1, 3'd2}, '{3'd0, 3'd2, 3'd3}
   };

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEN_A, ST_LEN_B, ST_MAG, ST_SQ, ST_T2, ST_PLO, ST_PHI,
      ST_CMP, ST_STORE, ST_EMIT
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_LEN_A, DP_LEN_B, DP_MAG, DP_SQ, DP_T2, DP_PLO, DP_PHI,
      DP_CMP, DP_STORE
   } dp_op_type;

   typedef struct packed {
      logic                  capture;
      logic                  base_clear;
      logic                  base_advance;
      dp_op_type             op;
      logic [1:0]            off_sel;
      logic [BIT_CNT_W-1:0]  bit_idx;
      logic                  emit_load;
      logic [EMIT_CNT_W-1:0] emit_idx;
      logic                  is_line;
   } dp_cmd_type;

   function automatic logic signed [COORD_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 17'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -17'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

/* src/aaq_req_if.sv */
// ----------------------------------------------------------------------------
// aaq_req_if
// Request channel: drawing command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aaq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [aaq_pkg::ACTION_W-1:0]         action;
   logic signed [aaq_pkg::COORD_W-1:0]   point_a_x;
   logic signed [aaq_pkg::COORD_W-1:0]   point_a_y;
   logic signed [aaq_pkg::COORD_W-1:0]   point_b_x;
   logic signed [aaq_pkg::COORD_W-1:0]   point_b_y;
   logic [aaq_pkg::WIDTH_W-1:0]          line_width;
   logic [aaq_pkg::COLOR_W-1:0]          red_in;
   logic [aaq_pkg::COLOR_W-1:0]          green_in;
   logic [aaq_pkg::COLOR_W-1:0]          blue_in;
   logic [aaq_pkg::COLOR_W-1:0]          alpha_in;

   modport source (output valid, action, point_a_x, point_a_y, point_b_x, point_b_y,
                   line_width, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink (input valid, action, point_a_x, point_a_y, point_b_x, point_b_y,
                 line_width, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

/* src/aaq_rsp_if.sv */
// ----------------------------------------------------------------------------
// aaq_rsp_if
// Result channel: vertex or triangle record with valid/ready handshake.
// ----------------------------------------------------------------------------
interface aaq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic signed [aaq_pkg::COORD_W-1:0] pos_x;
   logic signed [aaq_pkg::COORD_W-1:0] pos_y;
   logic [aaq_pkg::COLOR_W-1:0]        red_out;
   logic [aaq_pkg::COLOR_W-1:0]        green_out;
   logic [aaq_pkg::COLOR_W-1:0]        blue_out;
   logic [aaq_pkg::COLOR_W-1:0]        alpha_out;
   logic [aaq_pkg::IDX_W-1:0]          index_first;
   logic [aaq_pkg::IDX_W-1:0]          index_second;
   logic [aaq_pkg::IDX_W-1:0]          index_third;
   logic                               last;

   modport source (output valid, kind, pos_x, pos_y, red_out, green_out, blue_out,
                   alpha_out, index_first, index_second, index_third, last, input ready);
   modport sink (input valid, kind, pos_x, pos_y, red_out, green_out, blue_out,
                 alpha_out, index_first, index_second, index_third, last, output ready);
endinterface

/* src/aaq_ctrl.sv */
// ----------------------------------------------------------------------------
// aaq_ctrl
// Sequencer: walks the length, offset search and record emission steps.
// ----------------------------------------------------------------------------
module aaq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [aaq_pkg::ACTION_W-1:0]  req_action,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output aaq_pkg::dp_cmd_type           cmd
);

   aaq_pkg::state_type                   state_ff, state_in;
   logic [1:0]                           off_cnt_ff, off_cnt_in;
   logic [aaq_pkg::BIT_CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [aaq_pkg::EMIT_CNT_W-1:0]       emit_cnt_ff, emit_cnt_in;
   logic                                 is_line_ff, is_line_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 accept;
   logic                                 load;
   logic                                 emit_done;
   logic [aaq_pkg::EMIT_CNT_W-1:0]       emit_last;

   assign req_ready = (state_ff == aaq_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign load      = (state_ff == aaq_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign emit_last = is_line_ff ? aaq_pkg::LAST_LINE : aaq_pkg::LAST_RECT;
   assign emit_done = load && (emit_cnt_ff == emit_last);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aaq_pkg::ST_IDLE: begin
            if (accept && req_action == aaq_pkg::ACT_LINE) begin
               state_in = aaq_pkg::ST_LEN_A;
            end else if (accept && req_action == aaq_pkg::ACT_RECT) begin
               state_in = aaq_pkg::ST_EMIT;
            end
         end
         aaq_pkg::ST_LEN_A: state_in = aaq_pkg::ST_LEN_B;
         aaq_pkg::ST_LEN_B: state_in = aaq_pkg::ST_MAG;
         aaq_pkg::ST_MAG:   state_in = aaq_pkg::ST_SQ;
         aaq_pkg::ST_SQ:    state_in = aaq_pkg::ST_T2;
         aaq_pkg::ST_T2:    state_in = aaq_pkg::ST_PLO;
         aaq_pkg::ST_PLO:   state_in = aaq_pkg::ST_PHI;
         aaq_pkg::ST_PHI:   state_in = aaq_pkg::ST_CMP;
         aaq_pkg::ST_CMP: begin
            state_in = (bit_cnt_ff == '0) ? aaq_pkg::ST_STORE : aaq_pkg::ST_T2;
         end
         aaq_pkg::ST_STORE: begin
            state_in = (off_cnt_ff == 2'd3) ? aaq_pkg::ST_EMIT : aaq_pkg::ST_MAG;
         end
         aaq_pkg::ST_EMIT: begin
            if (emit_done) begin
               state_in = aaq_pkg::ST_IDLE;
            end
         end
         default: state_in = aaq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd              = '0;
      cmd.capture      = accept;
      cmd.base_clear   = accept && (req_action == aaq_pkg::ACT_CLEAR);
      cmd.base_advance = emit_done;
      cmd.off_sel      = off_cnt_ff;
      cmd.bit_idx      = bit_cnt_ff;
      cmd.emit_load    = load;
      cmd.emit_idx     = emit_cnt_ff;
      cmd.is_line      = is_line_ff;
      case (state_ff)
         aaq_pkg::ST_LEN_A: cmd.op = aaq_pkg::DP_LEN_A;
         aaq_pkg::ST_LEN_B: cmd.op = aaq_pkg::DP_LEN_B;
         aaq_pkg::ST_MAG:   cmd.op = aaq_pkg::DP_MAG;
         aaq_pkg::ST_SQ:    cmd.op = aaq_pkg::DP_SQ;
         aaq_pkg::ST_T2:    cmd.op = aaq_pkg::DP_T2;
         aaq_pkg::ST_PLO:   cmd.op = aaq_pkg::DP_PLO;
         aaq_pkg::ST_PHI:   cmd.op = aaq_pkg::DP_PHI;
         aaq_pkg::ST_CMP:   cmd.op = aaq_pkg::DP_CMP;
         aaq_pkg::ST_STORE: cmd.op = aaq_pkg::DP_STORE;
         default:           cmd.op = aaq_pkg::DP_NONE;
      endcase
   end

   always_comb begin
      off_cnt_in   = off_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      emit_cnt_in  = emit_cnt_ff;
      is_line_in   = is_line_ff;
      if (accept) begin
         off_cnt_in  = '0;
         emit_cnt_in = '0;
         is_line_in  = (req_action == aaq_pkg::ACT_LINE);
      end
      if (state_ff == aaq_pkg::ST_SQ) begin
         bit_cnt_in = aaq_pkg::BIT_CNT_W'(aaq_pkg::LO_BITS - 1);
      end
      if (state_ff == aaq_pkg::ST_CMP && bit_cnt_ff != '0) begin
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end
      if (state_ff == aaq_pkg::ST_STORE) begin
         off_cnt_in = off_cnt_ff + 1'b1;
      end
      if (load) begin
         emit_cnt_in = emit_cnt_ff + 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aaq_pkg::ST_IDLE;
         off_cnt_ff   <= '0;
         bit_cnt_ff   <= '0;
         emit_cnt_ff  <= '0;
         is_line_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         off_cnt_ff   <= off_cnt_in;
         bit_cnt_ff   <= bit_cnt_in;
         emit_cnt_ff  <= emit_cnt_in;
         is_line_ff   <= is_line_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* src/aaq_datapath.sv */
// ----------------------------------------------------------------------------
// aaq_datapath
// Command registers, perpendicular offset search and record formatting.
// ----------------------------------------------------------------------------
module aaq_datapath #(
   parameter int INDEX_BITS      = aaq_pkg::INDEX_BITS_DEF,
   parameter int COORD_FRAC_BITS = aaq_pkg::COORD_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  aaq_pkg::dp_cmd_type                 cmd,
   input  logic signed [aaq_pkg::COORD_W-1:0]  req_point_a_x,
   input  logic signed [aaq_pkg::COORD_W-1:0]  req_point_a_y,
   input  logic signed [aaq_pkg::COORD_W-1:0]  req_point_b_x,
   input  logic signed [aaq_pkg::COORD_W-1:0]  req_point_b_y,
   input  logic [aaq_pkg::WIDTH_W-1:0]         req_line_width,
   input  logic [aaq_pkg::COLOR_W-1:0]         req_red_in,
   input  logic [aaq_pkg::COLOR_W-1:0]         req_green_in,
   input  logic [aaq_pkg::COLOR_W-1:0]         req_blue_in,
   input  logic [aaq_pkg::COLOR_W-1:0]         req_alpha_in,
   output logic                                rsp_kind,
   output logic signed [aaq_pkg::COORD_W-1:0]  rsp_pos_x,
   output logic signed [aaq_pkg::COORD_W-1:0]  rsp_pos_y,
   output logic [aaq_pkg::COLOR_W-1:0]         rsp_red_out,
   output logic [aaq_pkg::COLOR_W-1:0]         rsp_green_out,
   output logic [aaq_pkg::COLOR_W-1:0]         rsp_blue_out,
   output logic [aaq_pkg::COLOR_W-1:0]         rsp_alpha_out,
   output logic [aaq_pkg::IDX_W-1:0]           rsp_index_first,
   output logic [aaq_pkg::IDX_W-1:0]           rsp_index_second,
   output logic [aaq_pkg::IDX_W-1:0]           rsp_index_third,
   output logic                                rsp_last
);

   localparam logic [aaq_pkg::Q4_W-1:0] ONE_Q   = aaq_pkg::Q4_W'(1 << COORD_FRAC_BITS);
   localparam logic [aaq_pkg::Q4_W-1:0] THREE_Q = aaq_pkg::Q4_W'(3 << COORD_FRAC_BITS);
   localparam logic [aaq_pkg::Q4_W-1:0] SIX_Q   = aaq_pkg::Q4_W'(6 << COORD_FRAC_BITS);
   localparam logic [aaq_pkg::Q4_W-1:0] FOUR_Q  = aaq_pkg::Q4_W'(4 << COORD_FRAC_BITS);

   logic signed [aaq_pkg::COORD_W-1:0]  ax_ff, ay_ff, bx_ff, by_ff;
   logic [aaq_pkg::COLOR_W-1:0]         red_ff, green_ff, blue_ff, alpha_ff;
   logic [aaq_pkg::Q4_W-1:0]            h4_ff, c4_ff, h4_in, c4_in;
   logic signed [aaq_pkg::SUM_W-1:0]    rx_ff, ry_ff;
   logic [aaq_pkg::SQ_W-1:0]            sq_ff;
   logic [aaq_pkg::LEN2_W-1:0]          len2_ff;
   logic [aaq_pkg::A_W-1:0]             a_ff;
   logic [aaq_pkg::A2_W-1:0]            a2_ff;
   logic [aaq_pkg::LO_BITS-1:0]         lo_ff;
   logic [aaq_pkg::T2_W-1:0]            t2_ff;
   logic [aaq_pkg::PLO_W-1:0]           plo_ff;
   logic [aaq_pkg::PHI_W-1:0]           phi_ff;
   logic signed [aaq_pkg::OFF_W-1:0]    ex_ff, ey_ff, cx_ff, cy_ff;
   logic [INDEX_BITS-1:0]               base_ff;

   logic [aaq_pkg::WIDTH_W-1:0]         ipart;
   logic [aaq_pkg::Q4_W-1:0]            w2;
   logic [aaq_pkg::MAG_W-1:0]           rx_mag, ry_mag, mag_sel;
   logic [aaq_pkg::Q4_W-1:0]            q4_sel;
   logic                                r_neg;
   logic [aaq_pkg::LO_BITS-1:0]         cand;
   logic [aaq_pkg::T_W-1:0]             t_val;
   logic [aaq_pkg::CMP_W-1:0]           prod;
   logic signed [aaq_pkg::OFF_W-1:0]    off_val;

   // record formatting
   logic [2:0]                          vk;
   logic [2:0]                          ti;
   logic                                is_tri;
   logic signed [aaq_pkg::COORD_W-1:0]  pt_x, pt_y;
   logic signed [aaq_pkg::OFF_W-1:0]    ofs_x, ofs_y;
   logic signed [aaq_pkg::SUM_W-1:0]    sum_x, sum_y;
   logic [2:0]                          c0, c1, c2;
   logic [INDEX_BITS-1:0]               i0, i1, i2;
   logic                                outer;

   // core and half widths in quarter steps
   always_comb begin
      ipart = req_line_width >> COORD_FRAC_BITS;
      w2    = {1'b0, req_line_width, 1'b0};
      h4_in = w2;
      if (ipart <= aaq_pkg::WIDTH_W'(1)) begin
         h4_in = w2 + ONE_Q;
         c4_in = ONE_Q;
      end else if (ipart == aaq_pkg::WIDTH_W'(2)) begin
         c4_in = THREE_Q;
      end else if (ipart == aaq_pkg::WIDTH_W'(3)) begin
         c4_in = SIX_Q;
      end else begin
         c4_in = w2 - FOUR_Q;
      end
   end

   always_comb begin
      rx_mag  = aaq_pkg::MAG_W'(rx_ff < 0 ? -rx_ff : rx_ff);
      ry_mag  = aaq_pkg::MAG_W'(ry_ff < 0 ? -ry_ff : ry_ff);
      mag_sel = cmd.off_sel[0] ? ry_mag : rx_mag;
      r_neg   = cmd.off_sel[0] ? ry_ff[aaq_pkg::SUM_W-1] : rx_ff[aaq_pkg::SUM_W-1];
      q4_sel  = cmd.off_sel[1] ? c4_ff : h4_ff;
      cand    = lo_ff | (aaq_pkg::LO_BITS'(1) << cmd.bit_idx);
      t_val   = {cand, 1'b0} - aaq_pkg::T_W'(1);
      prod    = aaq_pkg::CMP_W'({phi_ff, {aaq_pkg::LEN_LO_W{1'b0}}})
              + aaq_pkg::CMP_W'(plo_ff);
      // zero-length line gives zero offsets
      if (len2_ff == '0) begin
         off_val = '0;
      end else if (r_neg) begin
         off_val = -$signed({1'b0, lo_ff});
      end else begin
         off_val = $signed({1'b0, lo_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ax_ff    <= req_point_a_x;
         ay_ff    <= req_point_a_y;
         bx_ff    <= req_point_b_x;
         by_ff    <= req_point_b_y;
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
         alpha_ff <= req_alpha_in;
         h4_ff    <= h4_in;
         c4_ff    <= c4_in;
         rx_ff    <= aaq_pkg::SUM_W'(req_point_b_y) - aaq_pkg::SUM_W'(req_point_a_y);
         ry_ff    <= aaq_pkg::SUM_W'(req_point_a_x) - aaq_pkg::SUM_W'(req_point_b_x);
      end
      case (cmd.op)
         aaq_pkg::DP_LEN_A: sq_ff <= rx_mag * rx_mag;
         aaq_pkg::DP_LEN_B: len2_ff <= aaq_pkg::LEN2_W'(sq_ff)
                                    + aaq_pkg::LEN2_W'(aaq_pkg::SQ_W'(ry_mag)
                                                       * aaq_pkg::SQ_W'(ry_mag));
         aaq_pkg::DP_MAG: begin
            a_ff  <= mag_sel * q4_sel;
            lo_ff <= '0;
         end
         aaq_pkg::DP_SQ:  a2_ff <= a_ff * a_ff;
         aaq_pkg::DP_T2:  t2_ff <= t_val * t_val;
         aaq_pkg::DP_PLO: plo_ff <= t2_ff * len2_ff[aaq_pkg::LEN_LO_W-1:0];
         aaq_pkg::DP_PHI: phi_ff <= t2_ff * len2_ff[aaq_pkg::LEN2_W-1:aaq_pkg::LEN_LO_W];
         aaq_pkg::DP_CMP: begin
            // keep the bit while (2*lo-1)^2 * 4 * len2 <= a^2
            if ({prod[aaq_pkg::CMP_W-3:0], 2'b00} <= aaq_pkg::CMP_W'(a2_ff)) begin
               lo_ff[cmd.bit_idx] <= 1'b1;
            end
         end
         aaq_pkg::DP_STORE: begin
            case (cmd.off_sel)
               2'd0:    ex_ff <= off_val;
               2'd1:    ey_ff <= off_val;
               2'd2:    cx_ff <= off_val;
               default: cy_ff <= off_val;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else if (cmd.base_clear) begin
         base_ff <= '0;
      end else if (cmd.base_advance) begin
         base_ff <= base_ff + (cmd.is_line ? INDEX_BITS'(8) : INDEX_BITS'(4));
      end
   end

   always_comb begin
      vk     = cmd.emit_idx[2:0];
      is_tri = cmd.emit_idx >= (cmd.is_line ? aaq_pkg::LINE_VERTS : aaq_pkg::RECT_VERTS);
      ti     = cmd.is_line ? 3'(cmd.emit_idx - aaq_pkg::LINE_VERTS)
                           : 3'(cmd.emit_idx - aaq_pkg::RECT_VERTS);
      outer  = cmd.is_line && (vk[2:1] == 2'd0 || vk[2:1] == 2'd3);
      if (cmd.is_line) begin
         pt_x = vk[0] ? bx_ff : ax_ff;
         pt_y = vk[0] ? by_ff : ay_ff;
         case (vk[2:1])
            2'd0:    begin ofs_x = -ex_ff; ofs_y = -ey_ff; end
            2'd1:    begin ofs_x = -cx_ff; ofs_y = -cy_ff; end
            2'd2:    begin ofs_x = cx_ff;  ofs_y = cy_ff;  end
            default: begin ofs_x = ex_ff;  ofs_y = ey_ff;  end
         endcase
         sum_x = aaq_pkg::SUM_W'(pt_x) + aaq_pkg::SUM_W'(ofs_x);
         sum_y = aaq_pkg::SUM_W'(pt_y) + aaq_pkg::SUM_W'(ofs_y);
      end else begin
         pt_x  = ax_ff;
         pt_y  = ay_ff;
         ofs_x = '0;
         ofs_y = '0;
         sum_x = (vk[1:0] == 2'd2 || vk[1:0] == 2'd3)
               ? aaq_pkg::SUM_W'(ax_ff) + aaq_pkg::SUM_W'(bx_ff) : aaq_pkg::SUM_W'(ax_ff);
         sum_y = (vk[1:0] == 2'd0 || vk[1:0] == 2'd3)
               ? aaq_pkg::SUM_W'(ay_ff) + aaq_pkg::SUM_W'(by_ff) : aaq_pkg::SUM_W'(ay_ff);
      end
      if (cmd.is_line) begin
         c0 = aaq_pkg::LINE_TRI_TAB[ti][0];
         c1 = aaq_pkg::LINE_TRI_TAB[ti][1];
         c2 = aaq_pkg::LINE_TRI_TAB[ti][2];
      end else begin
         c0 = aaq_pkg::RECT_TRI_TAB[ti[0]][0];
         c1 = aaq_pkg::RECT_TRI_TAB[ti[0]][1];
         c2 = aaq_pkg::RECT_TRI_TAB[ti[0]][2];
      end
      i0 = base_ff + INDEX_BITS'(is_tri ? c0 : vk);
      i1 = base_ff + INDEX_BITS'(c1);
      i2 = base_ff + INDEX_BITS'(c2);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_kind         <= is_tri;
         rsp_pos_x        <= is_tri ? '0 : aaq_pkg::sat16(sum_x);
         rsp_pos_y        <= is_tri ? '0 : aaq_pkg::sat16(sum_y);
         rsp_red_out      <= is_tri ? '0 : red_ff;
         rsp_green_out    <= is_tri ? '0 : green_ff;
         rsp_blue_out     <= is_tri ? '0 : blue_ff;
         rsp_alpha_out    <= (is_tri || outer) ? '0 : alpha_ff;
         rsp_index_first  <= aaq_pkg::IDX_W'(i0);
         rsp_index_second <= is_tri ? aaq_pkg::IDX_W'(i1) : '0;
         rsp_index_third  <= is_tri ? aaq_pkg::IDX_W'(i2) : '0;
         rsp_last         <= cmd.base_advance;
      end
   end

endmodule

/* src/aa_line_quad_expander_unit.sv */
// ----------------------------------------------------------------------------
// aa_line_quad_expander_unit
// Expands line and fill-rectangle commands into vertex and triangle records.
//
//   channel    dir   handshake      payload
//   req_chan   in    valid/ready    drawing command
//   rsp_chan   out   valid/ready    vertex or triangle record
//
// A line computes its squared length, then searches 4 offsets of 12
// result bits each (a square, two partial products and a compare per
// bit), then emits 14 records at one a cycle. A rectangle emits 6 records,
// a clear none. Synchronous reset zeroes the vertex base; no clearing pass.
// A stalled result stalls emission; the next command is taken once the
// last record of the current one sits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aa_line_quad_expander_unit #(
   parameter int INDEX_BITS      = aaq_pkg::INDEX_BITS_DEF,
   parameter int COORD_FRAC_BITS = aaq_pkg::COORD_FRAC_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   aaq_req_if.sink   req_chan,
   aaq_rsp_if.source rsp_chan
);

   aaq_pkg::dp_cmd_type cmd;

   aaq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .cmd        (cmd)
   );

   aaq_datapath #(
      .INDEX_BITS      (INDEX_BITS),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_point_a_x    (req_chan.point_a_x),
      .req_point_a_y    (req_chan.point_a_y),
      .req_point_b_x    (req_chan.point_b_x),
      .req_point_b_y    (req_chan.point_b_y),
      .req_line_width   (req_chan.line_width),
      .req_red_in       (req_chan.red_in),
      .req_green_in     (req_chan.green_in),
      .req_blue_in      (req_chan.blue_in),
      .req_alpha_in     (req_chan.alpha_in),
      .rsp_kind         (rsp_chan.kind),
      .rsp_pos_x        (rsp_chan.pos_x),
      .rsp_pos_y        (rsp_chan.pos_y),
      .rsp_red_out      (rsp_chan.red_out),
      .rsp_green_out    (rsp_chan.green_out),
      .rsp_blue_out     (rsp_chan.blue_out),
      .rsp_alpha_out    (rsp_chan.alpha_out),
      .rsp_index_first  (rsp_chan.index_first),
      .rsp_index_second (rsp_chan.index_second),
      .rsp_index_third  (rsp_chan.index_third),
      .rsp_last         (rsp_chan.last)
   );

   `AAQ_ASSERT_IMPL(a_no_req_while_emit, clock, reset, cmd.emit_load, !req_chan.ready)
   `AAQ_ASSERT_NEXT(a_line_busy, clock, reset, req_chan.valid && req_chan.ready && req_chan.action == aaq_pkg::ACT_LINE, !req_chan.ready)
   `AAQ_ASSERT_IMPL(a_last_is_tri, clock, reset, rsp_chan.valid && rsp_chan.last, rsp_chan.kind)
   `AAQ_ASSERT_IMPL(a_vertex_idx, clock, reset, rsp_chan.valid && !rsp_chan.kind, rsp_chan.index_second == '0 && rsp_chan.index_third == '0)

endmodule
